// ===== rtl/htfc_pkg.sv =====
// Shared types, codes and constants for the humidity/temperature frame converter.
`timescale 1ns / 1ps

package htfc_pkg;

	localparam int FRAME_DEPTH = 6;
	localparam int POS_W       = 3;
	localparam int RAW_W       = 20;
	localparam int SUM_W       = 35;
	localparam int HEAT_W      = 9;
	localparam int CFG_DATA_W  = 11;

	// Conversion coefficients and rounding offsets, per sensor kind.
	localparam logic [14:0] K0_TEMP_MUL  = 15'd20000;
	localparam logic [14:0] K0_HUMID_MUL = 15'd10000;
	localparam logic [14:0] K1_TEMP_MUL  = 15'd17500;
	localparam logic [14:0] K1_HUMID_MUL = 15'd12500;
	localparam logic [SUM_W-1:0] K0_ROUND = SUM_W'(524288);
	localparam logic [SUM_W-1:0] K1_ROUND = SUM_W'(32767);
	localparam logic [16:0] K1_DIVISOR   = 17'd65535;

	localparam logic signed [15:0] K0_TEMP_OFS  = 16'sd5000;
	localparam logic signed [15:0] K1_TEMP_OFS  = 16'sd4500;
	localparam logic signed [15:0] K1_HUMID_OFS = 16'sd600;
	localparam logic signed [15:0] HUMID_MAX    = 16'sd10000;

	localparam logic [6:0]  PCT_MAX    = 7'd100;
	localparam logic [8:0]  HEAT_BASE  = 9'd150;
	localparam logic [12:0] RECIP_TEN  = 13'd6554;

	localparam logic signed [16:0] TEMP_LOW  = -17'sd2000;
	localparam logic signed [16:0] TEMP_HIGH = 17'sd7000;

	typedef enum logic [1:0] {
		CFG_SENSOR_KIND = 2'd0,
		CFG_BRIGHTNESS  = 2'd1,
		CFG_TEMP_TRIM   = 2'd2
	} htfc_cfg_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_BUSY        = 2'd1,
		ST_IMPLAUSIBLE = 2'd2
	} htfc_status_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_start;
	} htfc_in_t;

	typedef struct packed {
		logic signed [14:0] temp_centi;
		logic [13:0]        humid_centi;
		htfc_status_t       status;
	} htfc_out_t;

	// Raw sensor words of one finished frame.
	typedef struct packed {
		logic             kind;
		logic             busy;
		logic [RAW_W-1:0] raw_temp;
		logic [RAW_W-1:0] raw_humid;
	} htfc_raw_t;

	// Scaled, rounded products ahead of the final divide and correction.
	typedef struct packed {
		logic              kind;
		logic              busy;
		logic [SUM_W-1:0]  temp_sum;
		logic [SUM_W-1:0]  humid_sum;
		logic [HEAT_W-1:0] heat;
	} htfc_prod_t;

endpackage

// ===== rtl/htfc_frame.sv =====
// Frame assembly: byte position counter, frame byte buffer and raw word extraction.
`timescale 1ns / 1ps

module htfc_frame import htfc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      take,
	input  htfc_in_t  in_data,
	input  logic      kind,
	output logic      done,
	output htfc_raw_t raw
);

	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] pos_cur;
	logic [POS_W-1:0] pos_last;
	logic [7:0]       buf_q [FRAME_DEPTH];

	assign pos_cur  = in_data.frame_start ? '0 : pos_q;
	assign pos_last = kind ? POS_W'(5) : POS_W'(6);
	assign done     = (pos_cur >= pos_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (take) begin
			pos_q <= done ? '0 : pos_cur + POS_W'(1);
		end
	end

	// CRC byte at the end of a 7-byte frame is not kept.
	always_ff @(posedge clk) begin
		if (take && (pos_cur < POS_W'(FRAME_DEPTH))) begin
			buf_q[pos_cur] <= in_data.rx_byte;
		end
	end

	always_comb begin
		raw.kind = kind;
		raw.busy = !kind && buf_q[0][7];
		if (!kind) begin
			raw.raw_humid = {buf_q[1], buf_q[2], buf_q[3][7:4]};
			raw.raw_temp  = {buf_q[3][3:0], buf_q[4], buf_q[5]};
		end else begin
			raw.raw_temp  = {4'b0, buf_q[0], buf_q[1]};
			raw.raw_humid = {4'b0, buf_q[3], buf_q[4]};
		end
	end

endmodule

// ===== rtl/htfc_calc.sv =====
// Final scaling: divide/shift, offsets, self-heating correction, clamp and status.
`timescale 1ns / 1ps

module htfc_calc import htfc_pkg::*; (
	input  htfc_prod_t         prod,
	input  logic signed [10:0] trim,
	output htfc_out_t          res
);

	logic [14:0]        t0_q;
	logic [14:0]        h0_q;
	logic [14:0]        t1_q0;
	logic [14:0]        h1_q0;
	logic [16:0]        t1_rem;
	logic [16:0]        h1_rem;
	logic [14:0]        t1_q;
	logic [14:0]        h1_q;
	logic signed [15:0] t_base;
	logic signed [15:0] h_raw;
	logic [13:0]        humid;
	logic signed [16:0] temp;

	always_comb begin
		// Kind 0: divide by 2^20 is a shift.
		t0_q = prod.temp_sum[34:20];
		h0_q = prod.humid_sum[34:20];

		// Kind 1: divide by 65535, one correction step since remainder stays below twice it.
		t1_q0  = prod.temp_sum[30:16];
		h1_q0  = prod.humid_sum[30:16];
		t1_rem = 17'(prod.temp_sum[15:0]) + 17'(t1_q0);
		h1_rem = 17'(prod.humid_sum[15:0]) + 17'(h1_q0);
		t1_q   = t1_q0 + 15'(t1_rem >= K1_DIVISOR);
		h1_q   = h1_q0 + 15'(h1_rem >= K1_DIVISOR);

		if (!prod.kind) begin
			t_base = $signed({1'b0, t0_q}) - K0_TEMP_OFS;
			h_raw  = $signed({1'b0, h0_q});
		end else begin
			t_base = $signed({1'b0, t1_q}) - K1_TEMP_OFS;
			h_raw  = $signed({1'b0, h1_q}) - K1_HUMID_OFS;
		end

		if (h_raw < 16'sd0) begin
			humid = '0;
		end else if (h_raw > HUMID_MAX) begin
			humid = 14'(HUMID_MAX);
		end else begin
			humid = h_raw[13:0];
		end

		temp = 17'(t_base) - $signed({8'b0, prod.heat}) + 17'(trim);

		if (prod.busy) begin
			res.temp_centi  = '0;
			res.humid_centi = '0;
			res.status      = ST_BUSY;
		end else begin
			res.temp_centi  = temp[14:0];
			res.humid_centi = humid;
			res.status      = (temp > TEMP_LOW && temp < TEMP_HIGH) ? ST_OK : ST_IMPLAUSIBLE;
		end
	end

endmodule

// ===== rtl/humidity_temp_frame_convert.sv =====
// Top level: handshakes, configuration registers and the conversion pipeline.
// Takes one byte per cycle while in_stall is low; bytes that do not end a frame give no result.
// The result of a frame appears on out_valid once its last byte is taken and has passed
// the raw word register, then the product and output registers; the pipeline may take
// a new frame before the last one has left it.
// The constant-coefficient multiply sets the product stage; divide and correction fill the last.
// Reset clears the byte position, pipeline valids and registers to kind 0, 0 pct, no trim.
`timescale 1ns / 1ps

module humidity_temp_frame_convert import htfc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  htfc_in_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output htfc_out_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic               kind_q;
	logic [6:0]         bright_q;
	logic signed [10:0] trim_q;

	logic       in_take;
	logic       frame_done;
	htfc_raw_t  raw;

	logic       valid_s1;
	htfc_raw_t  raw_s1;
	logic       valid_s2;
	htfc_prod_t prod_s2;
	logic       out_valid_q;
	htfc_out_t  out_q;
	htfc_out_t  res;

	logic       out_adv;
	logic       s2_free;
	logic       s1_free;

	logic [6:0]        pct;
	logic [11:0]       heat_num;
	logic [24:0]       heat_scaled;
	logic [HEAT_W-1:0] heat;
	logic [14:0]       temp_mul;
	logic [14:0]       humid_mul;
	logic [SUM_W-1:0]  round_ofs;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q   <= 1'b0;
			bright_q <= '0;
			trim_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SENSOR_KIND: kind_q   <= cfg_data[0];
				CFG_BRIGHTNESS:  bright_q <= cfg_data[6:0];
				CFG_TEMP_TRIM:   trim_q   <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// Each stage advances when the one ahead frees up, so bubbles collapse.
	assign out_adv  = !out_valid_q || !out_stall;
	assign s2_free  = !valid_s2 || out_adv;
	assign s1_free  = !valid_s1 || s2_free;
	assign in_stall = !s1_free;
	assign in_take  = in_valid && !in_stall;

	htfc_frame u_frame (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (in_take),
		.in_data (in_data),
		.kind    (kind_q),
		.done    (frame_done),
		.raw     (raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= in_take && frame_done;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
			if (out_adv) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	// Self-heating: 150 + round(320 * pct / 100) = 150 + (32 * pct + 5) / 10.
	always_comb begin
		pct         = (bright_q > PCT_MAX) ? PCT_MAX : bright_q;
		heat_num    = {pct, 5'b0} + 12'd5;
		heat_scaled = 25'(heat_num) * 25'(RECIP_TEN);
		heat        = HEAT_BASE + heat_scaled[24:16];
		temp_mul    = raw_s1.kind ? K1_TEMP_MUL : K0_TEMP_MUL;
		humid_mul   = raw_s1.kind ? K1_HUMID_MUL : K0_HUMID_MUL;
		round_ofs   = raw_s1.kind ? K1_ROUND : K0_ROUND;
	end

	always_ff @(posedge clk) begin
		if (s1_free && in_take && frame_done) begin
			raw_s1 <= raw;
		end
		if (s2_free && valid_s1) begin
			prod_s2.kind      <= raw_s1.kind;
			prod_s2.busy      <= raw_s1.busy;
			prod_s2.temp_sum  <= SUM_W'(raw_s1.raw_temp) * SUM_W'(temp_mul) + round_ofs;
			prod_s2.humid_sum <= SUM_W'(raw_s1.raw_humid) * SUM_W'(humid_mul) + round_ofs;
			prod_s2.heat      <= heat;
		end
		if (out_adv && valid_s2) begin
			out_q <= res;
		end
	end

	htfc_calc u_calc (
		.prod (prod_s2),
		.trim (trim_q),
		.res  (res)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
